// ----- hdl/whl_pkg.sv -----
// Shared types, constants and character helpers for the whole-word line search.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package whl_pkg;

	localparam int NEEDLE_MAX_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;

	localparam int SIZE_W     = 5;   // needle size register
	localparam int SIZE_CMP_W = 8;   // room for sizes and cell positions up to 255
	localparam int FIELD_W    = 32;  // count and line fields of a result
	localparam int LIMIT_W    = 32;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int RES_DEPTH  = 4;   // result queue, power of two

	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_US     = 8'h5F;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam int         HIGH_BIT    = 7;  // set on bytes of 0x80 and up

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_LOW  = 3'd0,
		CFG_NEEDLE_HIGH = 3'd1,
		CFG_NEEDLE_SIZE = 3'd2,
		CFG_IGNORE_CASE = 3'd3,
		CFG_REPORT_LIM  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_MATCH   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_ABORT   = 2'd2,
		KIND_BAD_CFG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] subject_byte;
		logic       end_of_subject;
	} subj_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] line_index;
		logic [FIELD_W-1:0] reported_total;
		logic [FIELD_W-1:0] matched_total;
		logic               final_res;
	} res_t;

	// Control shared by every cell of the window chain
	typedef struct packed {
		logic              shift;
		logic              clear;
		logic              ignore_case;
		logic [SIZE_W-1:0] needle_size;
	} cell_ctl_t;

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
		       (c >= "0" && c <= "9") || (c == CHAR_US);
	endfunction

	function automatic logic [7:0] lower_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + CASE_OFFSET : c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/whl_cell.sv -----
// One position of the recent-byte window: holds a byte and its valid bit,
// checks it against its needle byte or as the leading word boundary. Uses whl_pkg.
`default_nettype none

module whl_cell #(
	parameter int IDX        = 0,
	parameter int NEEDLE_MAX = whl_pkg::NEEDLE_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire whl_pkg::cell_ctl_t          ctl,
	input  wire logic [NEEDLE_MAX-1:0][7:0]  needle,
	input  wire logic [7:0]                  byte_in,
	input  wire logic                        valid_in,
	output logic      [7:0]                  byte_q,
	output logic                             valid_q,
	output logic                             pass_cur,
	output logic                             pass_nxt
);
	import whl_pkg::*;

	localparam int NIW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [SIZE_CMP_W-1:0] size_w;
	logic [SIZE_CMP_W-1:0] pos_w;
	logic [SIZE_CMP_W-1:0] nidx;
	logic [7:0]            nbyte;
	logic [7:0]            cur_c;
	logic [7:0]            nxt_c;
	logic                  in_needle;
	logic                  at_edge;

	always_comb begin
		size_w    = {{(SIZE_CMP_W-SIZE_W){1'b0}}, ctl.needle_size};
		pos_w     = SIZE_CMP_W'(IDX);
		in_needle = pos_w < size_w;
		at_edge   = pos_w == size_w;
		// newest byte lines up with the last needle byte
		nidx      = size_w - pos_w - SIZE_CMP_W'(1);
		nbyte     = (nidx < SIZE_CMP_W'(NEEDLE_MAX)) ? needle[nidx[NIW-1:0]] : 8'd0;
		cur_c     = ctl.ignore_case ? lower_char(byte_q) : byte_q;
		nxt_c     = ctl.ignore_case ? lower_char(byte_in) : byte_in;
		if (in_needle) begin
			pass_cur = valid_q && (cur_c == nbyte);
			pass_nxt = valid_in && (nxt_c == nbyte);
		end else if (at_edge) begin
			pass_cur = !(valid_q && is_word_char(byte_q));
			pass_nxt = !(valid_in && is_word_char(byte_in));
		end else begin
			pass_cur = 1'b1;
			pass_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/whl_res_fifo.sv -----
// Small result queue: takes up to two results a cycle, gives one.
// Uses whl_pkg for the result type and depth.
`default_nettype none

module whl_res_fifo (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [1:0]                            push_cnt,
	input  wire whl_pkg::res_t [1:0]                   push_data,
	input  wire logic                                  pop,
	output whl_pkg::res_t                              head,
	output logic [$clog2(whl_pkg::RES_DEPTH):0]        level
);
	import whl_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);

	res_t          mem_q [0:RES_DEPTH-1];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   level_q;
	logic [PW-1:0] wr_next;

	assign wr_next = wr_ptr_q + PW'(1);
	assign head    = mem_q[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_next] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			level_q <= level_q + (PW+1)'(push_cnt) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/whole_word_line_search.sv -----
// Top level of the whole-word line search: config registers, line tracking,
// counters, the cell chain (whl_cell) and the result queue (whl_res_fifo). Uses whl_pkg.
//
//   channel | direction | handshake          | payload
//   subj    | in        | subj_valid/stall   | whl_pkg::subj_t (byte, end of subject)
//   res     | out       | res_valid/stall    | whl_pkg::res_t (kind, line, totals, final)
//   cfg     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One subject byte is taken per cycle while subj_stall is low; its window compare, line close
// and counter update complete in the cycle it is accepted, across the cell chain in parallel.
// A byte gives up to two results, queued and sent one per cycle while res_stall is low;
// subj_stall rises while the result queue has fewer than two free slots.
// Reset clears the line state, counters, window valid bits and queue, and loads
// the register defaults (needle size one, report limit all ones).
`default_nettype none

module whole_word_line_search #(
	parameter int NEEDLE_MAX = whl_pkg::NEEDLE_MAX_DEF,
	parameter int COUNT_BITS = whl_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          subj_valid,
	output logic                               subj_stall,
	input  wire whl_pkg::subj_t                subj,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output whl_pkg::res_t                      res,
	input  wire logic                          cfg_wr_en,
	input  wire logic [whl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [whl_pkg::CFG_W-1:0]     cfg_wdata
);
	import whl_pkg::*;

	localparam int CW  = COUNT_BITS;
	localparam int LVW = $clog2(RES_DEPTH) + 1;
	localparam int WW  = CW + LIMIT_W;

	// configuration
	logic [63:0]         needle_lo_q;
	logic [63:0]         needle_hi_q;
	logic [SIZE_W-1:0]   needle_size_q;
	logic                ignore_case_q;
	logic [LIMIT_W-1:0]  report_limit_q;

	// subject state
	logic                line_hit_q;
	logic [CW-1:0]       current_line_q;
	logic                after_cr_q;
	logic                aborted_q;
	logic [CW-1:0]       hit_lines_q;
	logic [CW-1:0]       sent_lines_q;

	logic [NEEDLE_MAX-1:0][7:0] needle;
	logic [7:0]                 chain_byte  [0:NEEDLE_MAX+1];
	logic [NEEDLE_MAX+1:0]      chain_valid;
	logic [NEEDLE_MAX:0]        pass_cur;
	logic [NEEDLE_MAX:0]        pass_nxt;
	cell_ctl_t                  ctl;

	logic            take;
	logic [7:0]      b;
	logic            eos;
	logic            bad;
	logic            act;
	logic            hi_byte;
	logic            is_lf;
	logic            is_cr;
	logic            do_abort;
	logic            skip_lf;
	logic            brk;
	logic            reg_byte;
	logic            probe_cur;
	logic            probe_nxt;
	logic            line_hit_new;
	logic            eos_close;
	logic            hit_b;
	logic            hit_e;
	logic            matched;
	logic            room;
	logic            report;
	logic [CW-1:0]   sent_next;
	logic [CW-1:0]   hit_next;
	logic [CW-1:0]   line_next;
	logic [WW-1:0]   cur_line_ext;
	logic [WW-1:0]   sent_ext;
	logic [WW-1:0]   rep_ext;
	logic [WW-1:0]   hit_ext;
	logic [WW-1:0]   limit_ext;
	res_t            match_res;
	res_t            sum_res;
	res_t [1:0]      push_data;
	logic [1:0]      push_cnt;
	logic [LVW-1:0]  fifo_level;

	// needle bytes past the two registers read as zero
	for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_needle
		if (j < 8) begin : g_lo
			assign needle[j] = needle_lo_q[8*j +: 8];
		end else if (j < 16) begin : g_hi
			assign needle[j] = needle_hi_q[8*(j-8) +: 8];
		end else begin : g_zero
			assign needle[j] = 8'd0;
		end
	end

	assign chain_byte[0]  = subj.subject_byte;
	assign chain_valid[0] = 1'b1;

	for (genvar i = 0; i <= NEEDLE_MAX; i++) begin : g_cell
		whl_cell #(
			.IDX        (i),
			.NEEDLE_MAX (NEEDLE_MAX)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.needle   (needle),
			.byte_in  (chain_byte[i]),
			.valid_in (chain_valid[i]),
			.byte_q   (chain_byte[i+1]),
			.valid_q  (chain_valid[i+1]),
			.pass_cur (pass_cur[i]),
			.pass_nxt (pass_nxt[i])
		);
	end

	assign take      = subj_valid && !subj_stall;
	assign b         = subj.subject_byte;
	assign eos       = subj.end_of_subject;
	assign probe_cur = &pass_cur;
	assign probe_nxt = &pass_nxt;

	always_comb begin
		bad      = (needle_size_q == '0) ||
		           ({{(SIZE_CMP_W-SIZE_W){1'b0}}, needle_size_q} > SIZE_CMP_W'(NEEDLE_MAX));
		act      = take && !bad && !aborted_q;
		hi_byte  = b[HIGH_BIT];
		is_lf    = b == CHAR_LF;
		is_cr    = b == CHAR_CR;
		do_abort = act && hi_byte;
		skip_lf  = act && is_lf && after_cr_q;
		brk      = act && (is_cr || (is_lf && !after_cr_q));
		reg_byte = act && !hi_byte && !is_lf && !is_cr;

		// occurrence ending at the newest byte, closed by a non-word byte
		line_hit_new = line_hit_q || (reg_byte && probe_cur && !is_word_char(b));
		eos_close    = take && eos && !bad && !aborted_q && !do_abort;
		hit_b        = brk && (line_hit_q || probe_cur);
		// after a break close the line is empty and cannot match
		hit_e        = eos_close && (reg_byte ? (line_hit_new || probe_nxt) :
		                             (!brk && (line_hit_q || probe_cur)));
		matched      = hit_b || hit_e;

		sent_ext  = {{LIMIT_W{1'b0}}, sent_lines_q};
		limit_ext = {{CW{1'b0}}, report_limit_q};
		room      = sent_ext < limit_ext;
		report    = matched && room;

		sent_next = (report && !(&sent_lines_q)) ? sent_lines_q + CW'(1) : sent_lines_q;
		hit_next  = (matched && !(&hit_lines_q)) ? hit_lines_q + CW'(1) : hit_lines_q;
		line_next = (&current_line_q) ? current_line_q : current_line_q + CW'(1);

		cur_line_ext = {{LIMIT_W{1'b0}}, current_line_q};
		rep_ext      = {{LIMIT_W{1'b0}}, sent_next};
		hit_ext      = {{LIMIT_W{1'b0}}, hit_next};

		match_res                = '0;
		match_res.kind           = KIND_MATCH;
		match_res.line_index     = cur_line_ext[FIELD_W-1:0];

		sum_res                  = '0;
		sum_res.final_res        = 1'b1;
		if (bad) begin
			sum_res.kind = KIND_BAD_CFG;
		end else if (aborted_q || do_abort) begin
			sum_res.kind = KIND_ABORT;
		end else begin
			sum_res.kind           = KIND_SUMMARY;
			sum_res.reported_total = rep_ext[FIELD_W-1:0];
			sum_res.matched_total  = hit_ext[FIELD_W-1:0];
		end

		match_res.final_res = !eos;
		push_data[1]        = sum_res;
		push_data[0]        = report ? match_res : sum_res;
		push_cnt            = take ? (2'(report) + 2'(eos)) : 2'd0;

		ctl.shift       = reg_byte;
		ctl.clear       = (take && eos) || brk;
		ctl.ignore_case = ignore_case_q;
		ctl.needle_size = needle_size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q    <= '0;
			needle_hi_q    <= '0;
			needle_size_q  <= SIZE_W'(1);
			ignore_case_q  <= 1'b0;
			report_limit_q <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NEEDLE_LOW:  needle_lo_q    <= cfg_wdata;
				CFG_NEEDLE_HIGH: needle_hi_q    <= cfg_wdata;
				CFG_NEEDLE_SIZE: needle_size_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_IGNORE_CASE: ignore_case_q  <= cfg_wdata[0];
				CFG_REPORT_LIM:  report_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_hit_q     <= 1'b0;
			current_line_q <= '0;
			after_cr_q     <= 1'b0;
			aborted_q      <= 1'b0;
			hit_lines_q    <= '0;
			sent_lines_q   <= '0;
		end else if (take) begin
			if (eos) begin
				// drop all per-subject state
				line_hit_q     <= 1'b0;
				current_line_q <= '0;
				after_cr_q     <= 1'b0;
				aborted_q      <= 1'b0;
				hit_lines_q    <= '0;
				sent_lines_q   <= '0;
			end else begin
				if (do_abort) begin
					aborted_q <= 1'b1;
				end
				if (skip_lf || reg_byte) begin
					after_cr_q <= 1'b0;
				end else if (brk) begin
					after_cr_q <= is_cr;
				end
				if (brk) begin
					line_hit_q     <= 1'b0;
					current_line_q <= line_next;
				end else if (reg_byte) begin
					line_hit_q <= line_hit_new;
				end
				hit_lines_q  <= hit_next;
				sent_lines_q <= sent_next;
			end
		end
	end

	whl_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (push_data),
		.pop       (res_valid && !res_stall),
		.head      (res),
		.level     (fifo_level)
	);

	assign res_valid  = fifo_level != '0;
	assign subj_stall = fifo_level > LVW'(RES_DEPTH - 2);

endmodule

`default_nettype wire
